/* src/lcdr_pkg.sv */
// Shared types and constants for the character LCD refresh controller.
`timescale 1ns / 1ps
`default_nettype none

package lcdr_pkg;

    localparam int SCREEN_CHARS  = 32;
    localparam int LINE_CHARS    = 16;
    localparam int IDX_W         = $clog2(SCREEN_CHARS);
    localparam int POS_W         = 7;
    localparam int NUM_SLOTS     = 5;
    localparam int NIBBLE_W      = 4;
    localparam int BURST_BYTES   = 5;
    localparam int BURST_NIBBLES = 2 * BURST_BYTES;
    localparam int COUNT_W       = $clog2(BURST_NIBBLES + 1);

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam int         LINE2_BASE   = 'h40;

    localparam logic [COUNT_W-1:0] TICK_NIBBLES = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] INIT_NIBBLES = COUNT_W'(BURST_NIBBLES);

    localparam logic [7:0] INIT_CMDS [BURST_BYTES] = '{8'h03, 8'h02, 8'h02, 8'h0C, 8'h06};

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_STRING = 2'd1,
        ACT_NUMBER = 2'd2,
        ACT_INIT   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        PH_CHAR  = 3'b001,
        PH_LINE1 = 3'b010,
        PH_LINE2 = 3'b100
    } refresh_phase_t;

    typedef struct packed {
        action_t     action;
        logic [5:0]  start_position;
        logic [5:0]  text_length;
        logic [5:0]  char_offset;
        logic [7:0]  char_code;
        logic [15:0] value;
        logic [12:0] q1;
        logic [9:0]  q2;
        logic [6:0]  q3;
        logic [2:0]  q4;
    } item_t;

    typedef struct packed {
        logic                                load;
        logic                                rs;
        logic [COUNT_W-1:0]                  count;
        logic [BURST_NIBBLES*NIBBLE_W-1:0]   nibbles;
    } burst_t;

endpackage

`default_nettype wire

/* src/char_lcd_refresh_controller_core.sv */
// Items are registered at the input; a tick or init then loads its nibbles into the
// single result register, waiting while that register still has unsent nibbles.
// A buffer write every cycle unless a tick or init is held; ticks have two nibbles.
// Reset: buffer filled with spaces, refresh index 0, next tick sends the line-one
// address; no beat is pending on either channel.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_refresh_controller_core
    import lcdr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [5:0]  s_start_position,
    input  wire logic [5:0]  s_text_length,
    input  wire logic [5:0]  s_char_offset,
    input  wire logic [7:0]  s_char_code,
    input  wire logic [15:0] s_number_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_register_select,
    output logic [3:0]       m_nibble,
    output logic             m_last_nibble
);

    logic   item_valid;
    item_t  item;
    logic   item_take;
    logic   out_free;
    burst_t burst;

    lcdr_in_stage u_in_stage (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_start_position (s_start_position),
        .s_text_length    (s_text_length),
        .s_char_offset    (s_char_offset),
        .s_char_code      (s_char_code),
        .s_number_value   (s_number_value),
        .item_take        (item_take),
        .item_valid       (item_valid),
        .item             (item)
    );

    lcdr_screen u_screen (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .item_take  (item_take),
        .burst      (burst)
    );

    lcdr_nibble_out u_nibble_out (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .burst             (burst),
        .out_free          (out_free),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_register_select (m_register_select),
        .m_nibble          (m_nibble),
        .m_last_nibble     (m_last_nibble)
    );

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        burst.load |-> out_free)
        else $error("burst loaded over pending nibbles");

    a_burst_size: assert property (@(posedge aclk) disable iff (!aresetn)
        burst.load |-> (burst.count == TICK_NIBBLES) || (burst.count == INIT_NIBBLES))
        else $error("burst length is neither a tick nor an init");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_nibble && !burst.load) |=> !m_valid)
        else $error("beat pending after last nibble");

    a_stall_means_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (item_valid && !item_take))
        else $error("input stalled with no held item");

endmodule

`default_nettype wire

/* src/lcdr_in_stage.sv */
// Input register with decimal quotient precompute for the number path.
`timescale 1ns / 1ps
`default_nettype none

module lcdr_in_stage
    import lcdr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [5:0]  s_start_position,
    input  wire logic [5:0]  s_text_length,
    input  wire logic [5:0]  s_char_offset,
    input  wire logic [7:0]  s_char_code,
    input  wire logic [15:0] s_number_value,
    input  wire logic        item_take,
    output logic             item_valid,
    output item_t            item
);

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;
    logic [31:0] prod10;
    logic [39:0] prod100;
    logic [39:0] prod1000;
    logic [47:0] prod10000;

    assign s_ready = !valid_reg || item_take;

    // reciprocal multiplies, exact over the 16-bit range
    assign prod10    = 32'(s_number_value) * 32'd52429;
    assign prod100   = 40'(s_number_value) * 40'd167773;
    assign prod1000  = 40'(s_number_value) * 40'd1073742;
    assign prod10000 = 48'(s_number_value) * 48'd429497;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_valid && s_ready) begin
            valid_next               = 1'b1;
            item_next.action         = action_t'(s_action);
            item_next.start_position = s_start_position;
            item_next.text_length    = s_text_length;
            item_next.char_offset    = s_char_offset;
            item_next.char_code      = s_char_code;
            item_next.value          = s_number_value;
            item_next.q1             = 13'(prod10 >> 19);
            item_next.q2             = 10'(prod100 >> 24);
            item_next.q3             = 7'(prod1000 >> 30);
            item_next.q4             = 3'(prod10000 >> 32);
        end else if (item_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

/* src/lcdr_screen.sv */
// Screen buffer, refresh sequencer and byte generation for tick and init items.
`timescale 1ns / 1ps
`default_nettype none

module lcdr_screen
    import lcdr_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  item_valid,
    input  wire item_t item,
    input  wire logic  out_free,
    output logic       item_take,
    output burst_t     burst
);

    logic [7:0]     screen_reg  [SCREEN_CHARS];
    logic [7:0]     screen_next [SCREEN_CHARS];
    logic [IDX_W-1:0] idx_reg, idx_next;
    refresh_phase_t phase_reg, phase_next;

    logic             emits;
    logic [3:0]       dig [NUM_SLOTS];
    logic [2:0]       ndig;
    logic [2:0]       nwrite;
    logic             num_we  [NUM_SLOTS];
    logic [POS_W-1:0] num_pos [NUM_SLOTS];
    logic [7:0]       num_chr [NUM_SLOTS];
    logic             str_ok;
    logic [POS_W-1:0] str_pos;

    assign emits     = (item.action == ACT_TICK) || (item.action == ACT_INIT);
    assign item_take = item_valid && (!emits || out_free);

    assign dig[0] = 4'(item.value - 16'(item.q1) * 16'd10);
    assign dig[1] = 4'(item.q1 - 13'(item.q2) * 13'd10);
    assign dig[2] = 4'(item.q2 - 10'(item.q3) * 10'd10);
    assign dig[3] = 4'(item.q3 - 7'(item.q4) * 7'd10);
    assign dig[4] = 4'(item.q4);

    always_comb begin
        if (item.value < 16'd10) begin
            ndig = 3'd1;
        end else if (item.value < 16'd100) begin
            ndig = 3'd2;
        end else if (item.value < 16'd1000) begin
            ndig = 3'd3;
        end else if (item.value < 16'd10000) begin
            ndig = 3'd4;
        end else begin
            ndig = 3'd5;
        end
        nwrite = (ndig == 3'd3) ? 3'd4 : 3'd5;
    end

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            logic [2:0] sel;
            sel        = ndig - 3'd1 - 3'(i);
            num_pos[i] = POS_W'(item.start_position) + POS_W'(i);
            num_we[i]  = (item.value != 16'd0) && (3'(i) < nwrite)
                         && (num_pos[i] < POS_W'(SCREEN_CHARS));
            if (3'(i) < ndig) begin
                unique case (sel)
                    3'd0:    num_chr[i] = CHAR_ZERO | 8'(dig[0]);
                    3'd1:    num_chr[i] = CHAR_ZERO | 8'(dig[1]);
                    3'd2:    num_chr[i] = CHAR_ZERO | 8'(dig[2]);
                    3'd3:    num_chr[i] = CHAR_ZERO | 8'(dig[3]);
                    default: num_chr[i] = CHAR_ZERO | 8'(dig[4]);
                endcase
            end else begin
                num_chr[i] = CHAR_SPACE;
            end
        end
    end

    assign str_ok = (POS_W'(item.start_position) + POS_W'(item.text_length)
                     <= POS_W'(SCREEN_CHARS))
                    && (item.char_offset < item.text_length);
    assign str_pos = POS_W'(item.start_position) + POS_W'(item.char_offset);

    always_comb begin
        logic [7:0]       tick_byte;
        logic             tick_rs;
        logic [IDX_W:0]   idx_inc;
        logic [POS_W-1:0] line2_addr;
        screen_next = screen_reg;
        idx_next    = idx_reg;
        phase_next  = phase_reg;
        burst       = '0;
        tick_byte   = '0;
        tick_rs     = 1'b0;
        idx_inc     = (IDX_W+1)'(idx_reg) + (IDX_W+1)'(1);
        line2_addr  = POS_W'(idx_reg) + POS_W'(LINE2_BASE - LINE_CHARS);
        if (item_take) begin
            unique case (item.action)
                ACT_TICK: begin
                    unique case (phase_reg)
                        PH_LINE1: begin
                            tick_byte  = CMD_SET_ADDR | 8'(idx_reg);
                            phase_next = PH_CHAR;
                        end
                        PH_LINE2: begin
                            tick_byte  = CMD_SET_ADDR | 8'(line2_addr);
                            phase_next = PH_CHAR;
                        end
                        default: begin
                            tick_byte = screen_reg[idx_reg];
                            tick_rs   = 1'b1;
                            if (idx_inc == (IDX_W+1)'(SCREEN_CHARS)) begin
                                idx_next   = '0;
                                phase_next = PH_LINE1;
                            end else if (idx_inc == (IDX_W+1)'(LINE_CHARS)) begin
                                idx_next   = idx_inc[IDX_W-1:0];
                                phase_next = PH_LINE2;
                            end else begin
                                idx_next   = idx_inc[IDX_W-1:0];
                                phase_next = PH_CHAR;
                            end
                        end
                    endcase
                    burst.load        = 1'b1;
                    burst.rs          = tick_rs;
                    burst.count       = TICK_NIBBLES;
                    burst.nibbles[0 +: NIBBLE_W]        = tick_byte[7:4];
                    burst.nibbles[NIBBLE_W +: NIBBLE_W] = tick_byte[3:0];
                end
                ACT_STRING: begin
                    for (int e = 0; e < SCREEN_CHARS; e++) begin
                        if (str_ok && (str_pos == POS_W'(e))) begin
                            screen_next[e] = item.char_code;
                        end
                    end
                end
                ACT_NUMBER: begin
                    for (int e = 0; e < SCREEN_CHARS; e++) begin
                        for (int i = 0; i < NUM_SLOTS; i++) begin
                            if (num_we[i] && (num_pos[i] == POS_W'(e))) begin
                                screen_next[e] = num_chr[i];
                            end
                        end
                    end
                end
                default: begin
                    for (int e = 0; e < SCREEN_CHARS; e++) begin
                        screen_next[e] = CHAR_SPACE;
                    end
                    idx_next    = '0;
                    burst.load  = 1'b1;
                    burst.rs    = 1'b0;
                    burst.count = INIT_NIBBLES;
                    for (int b = 0; b < BURST_BYTES; b++) begin
                        burst.nibbles[(2*b)*NIBBLE_W +: NIBBLE_W]   = INIT_CMDS[b][7:4];
                        burst.nibbles[(2*b+1)*NIBBLE_W +: NIBBLE_W] = INIT_CMDS[b][3:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int e = 0; e < SCREEN_CHARS; e++) begin
                screen_reg[e] <= CHAR_SPACE;
            end
            idx_reg   <= '0;
            phase_reg <= PH_LINE1;
        end else begin
            screen_reg <= screen_next;
            idx_reg    <= idx_next;
            phase_reg  <= phase_next;
        end
    end

endmodule

`default_nettype wire

/* src/lcdr_nibble_out.sv */
// Result register that shifts out the nibbles of one item, one beat at a time.
`timescale 1ns / 1ps
`default_nettype none

module lcdr_nibble_out
    import lcdr_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire burst_t burst,
    output logic        out_free,
    output logic        m_valid,
    input  wire logic   m_ready,
    output logic        m_register_select,
    output logic [3:0]  m_nibble,
    output logic        m_last_nibble
);

    logic [COUNT_W-1:0]                cnt_reg, cnt_next;
    logic [BURST_NIBBLES*NIBBLE_W-1:0] sh_reg, sh_next;
    logic                              rs_reg, rs_next;

    assign m_valid  = (cnt_reg != '0);
    assign out_free = (cnt_reg == '0) || ((cnt_reg == COUNT_W'(1)) && m_ready);

    always_comb begin
        cnt_next = cnt_reg;
        sh_next  = sh_reg;
        rs_next  = rs_reg;
        if (burst.load) begin
            cnt_next = burst.count;
            sh_next  = burst.nibbles;
            rs_next  = burst.rs;
        end else if (m_valid && m_ready) begin
            cnt_next = cnt_reg - COUNT_W'(1);
            sh_next  = sh_reg >> NIBBLE_W;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg <= sh_next;
        rs_reg <= rs_next;
    end

    assign m_register_select = rs_reg;
    assign m_nibble          = sh_reg[NIBBLE_W-1:0];
    assign m_last_nibble     = (cnt_reg == COUNT_W'(1));

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the character LCD refresh controller core.
`timescale 1ns / 1ps

module testbench;
    import lcdr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 450;
    localparam int TAIL_CYCLES  = 20;
    localparam logic [7:0] PANEL_SETUP [5] = '{8'h03, 8'h02, 8'h02, 8'h0C, 8'h06};

    typedef struct {
        action_t     action;
        logic [5:0]  start_position;
        logic [5:0]  text_length;
        logic [5:0]  char_offset;
        logic [7:0]  char_code;
        logic [15:0] number_value;
    } lcd_request_t;

    typedef struct {
        logic       rs;
        logic [3:0] nib;
        logic       last;
    } lcd_nibble_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    wire         s_ready;
    logic [1:0]  s_action = '0;
    logic [5:0]  s_start_position = '0;
    logic [5:0]  s_text_length = '0;
    logic [5:0]  s_char_offset = '0;
    logic [7:0]  s_char_code = '0;
    logic [15:0] s_number_value = '0;
    wire         m_valid;
    logic        m_ready = 1'b0;
    wire         m_register_select;
    wire  [3:0]  m_nibble;
    wire         m_last_nibble;

    lcd_request_t   pending_requests[$];
    lcd_nibble_t    expected_nibbles[$];
    logic [7:0]     screen_copy [SCREEN_CHARS];
    int             refresh_pos;
    refresh_phase_t refresh_step;
    int             failures = 0;
    int             cycle_count = 0;
    int             drv_cycle = 0;
    int             rx_cycle = 0;
    lcd_request_t   drv_item;

    char_lcd_refresh_controller_core u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_start_position  (s_start_position),
        .s_text_length     (s_text_length),
        .s_char_offset     (s_char_offset),
        .s_char_code       (s_char_code),
        .s_number_value    (s_number_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_register_select (m_register_select),
        .m_nibble          (m_nibble),
        .m_last_nibble     (m_last_nibble)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        for (int i = 0; i < SCREEN_CHARS; i++) screen_copy[i] = CHAR_SPACE;
        refresh_pos  = 0;
        refresh_step = PH_LINE1;
    end

    function automatic void push_lcd_byte(input logic rs, input logic [7:0] b, input logic last);
        expected_nibbles.push_back('{rs, b[7:4], 1'b0});
        expected_nibbles.push_back('{rs, b[3:0], last});
    endfunction

    function automatic void store_char(input int pos, input logic [7:0] c);
        if (pos < SCREEN_CHARS) screen_copy[pos] = c;
    endfunction

    function automatic void predict_lcd_request(input lcd_request_t it);
        int         ndig;
        int         npad;
        int         v;
        int         start;
        logic [7:0] digits [5];
        start = int'(it.start_position);
        case (it.action)
            ACT_TICK: begin
                case (refresh_step)
                    PH_LINE1: begin
                        push_lcd_byte(1'b0, CMD_SET_ADDR | 8'(refresh_pos & 'h7F), 1'b1);
                        refresh_step = PH_CHAR;
                    end
                    PH_LINE2: begin
                        push_lcd_byte(1'b0,
                            CMD_SET_ADDR | 8'((refresh_pos + LINE2_BASE - LINE_CHARS) & 'h7F),
                            1'b1);
                        refresh_step = PH_CHAR;
                    end
                    default: begin
                        push_lcd_byte(1'b1, screen_copy[refresh_pos], 1'b1);
                        refresh_pos++;
                        refresh_step = PH_CHAR;
                        if (refresh_pos >= SCREEN_CHARS) begin
                            refresh_pos  = 0;
                            refresh_step = PH_LINE1;
                        end else if (refresh_pos == LINE_CHARS) begin
                            refresh_step = PH_LINE2;
                        end
                    end
                endcase
            end
            ACT_STRING: begin
                if (start + int'(it.text_length) <= SCREEN_CHARS
                        && it.char_offset < it.text_length)
                    store_char(start + int'(it.char_offset), it.char_code);
            end
            ACT_NUMBER: begin
                v = int'(it.number_value);
                if (v != 0) begin
                    if (v < 10) begin
                        ndig = 1; npad = 4;
                    end else if (v < 100) begin
                        ndig = 2; npad = 3;
                    end else if (v < 1000) begin
                        ndig = 3; npad = 1;
                    end else if (v < 10000) begin
                        ndig = 4; npad = 1;
                    end else begin
                        ndig = 5; npad = 0;
                    end
                    for (int i = 0; i < ndig; i++) begin
                        digits[ndig - 1 - i] = CHAR_ZERO + 8'(v % 10);
                        v = v / 10;
                    end
                    for (int i = 0; i < ndig; i++) store_char(start + i, digits[i]);
                    for (int i = 0; i < npad; i++) store_char(start + ndig + i, CHAR_SPACE);
                end
            end
            default: begin
                for (int i = 0; i < SCREEN_CHARS; i++) screen_copy[i] = CHAR_SPACE;
                refresh_pos = 0;
                for (int i = 0; i < 5; i++) push_lcd_byte(1'b0, PANEL_SETUP[i], i == 4);
            end
        endcase
    endfunction

    function automatic void queue_request(input action_t a, input int start, input int len,
                                          input int off, input int code, input int num);
        lcd_request_t it;
        it.action         = a;
        it.start_position = 6'(start);
        it.text_length    = 6'(len);
        it.char_offset    = 6'(off);
        it.char_code      = 8'(code);
        it.number_value   = 16'(num);
        pending_requests.push_back(it);
    endfunction

    function automatic int pick_number();
        case ($urandom_range(6))
            0: return $urandom_range(1, 9);
            1: return $urandom_range(10, 99);
            2: return $urandom_range(100, 999);
            3: return $urandom_range(1000, 9999);
            4: return $urandom_range(10000, 65535);
            5: return 0;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // driver: offer one beat at a time from the pending queue
    always @(posedge aclk) begin
        bit idle;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            drv_cycle++;
            if (s_valid && s_ready) predict_lcd_request(drv_item);
            if (!s_valid || s_ready) begin
                idle = !(drv_cycle >= 900 && drv_cycle < 1300) && ($urandom_range(99) < 26);
                if (pending_requests.size() != 0 && !idle) begin
                    drv_item = pending_requests.pop_front();
                    s_action         <= drv_item.action;
                    s_start_position <= drv_item.start_position;
                    s_text_length    <= drv_item.text_length;
                    s_char_offset    <= drv_item.char_offset;
                    s_char_code      <= drv_item.char_code;
                    s_number_value   <= drv_item.number_value;
                    s_valid          <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random back-pressure, one long hold-off, one stretch always ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle >= 300 && rx_cycle < 700)
                m_ready <= 1'b0;
            else if (rx_cycle >= 900 && rx_cycle < 1300)
                m_ready <= 1'b1;
            else
                m_ready <= ($urandom_range(99) >= 26);
        end
    end

    // monitor: compare each beat with the oldest expected nibble
    always @(posedge aclk) begin
        lcd_nibble_t exp_nib;
        if (aresetn && m_valid && m_ready) begin
            if (expected_nibbles.size() == 0) begin
                $error("unexpected beat: rs %0d nibble %h last %0d",
                       m_register_select, m_nibble, m_last_nibble);
                failures++;
            end else begin
                exp_nib = expected_nibbles.pop_front();
                if (m_register_select !== exp_nib.rs) begin
                    $error("register_select: expected %0d, actual %0d",
                           exp_nib.rs, m_register_select);
                    failures++;
                end
                if (m_nibble !== exp_nib.nib) begin
                    $error("nibble: expected %h, actual %h", exp_nib.nib, m_nibble);
                    failures++;
                end
                if (m_last_nibble !== exp_nib.last) begin
                    $error("last_nibble: expected %0d, actual %0d",
                           exp_nib.last, m_last_nibble);
                    failures++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int stim_count;
        int sel;
        int len;
        int start;
        stim_count = 0;

        queue_request(ACT_TICK,    0,  0,  0, 8'h00, 0);
        queue_request(ACT_STRING,  0, 32, 31, 8'hFF, 0);
        queue_request(ACT_STRING,  0,  1,  0, 8'h00, 0);
        queue_request(ACT_STRING, 31,  1,  0, 8'h41, 0);
        queue_request(ACT_STRING, 63, 63, 63, 8'hAA, 65535);
        queue_request(ACT_STRING,  1, 32,  0, 8'h42, 0);
        queue_request(ACT_STRING,  2,  5,  5, 8'h43, 0);
        queue_request(ACT_STRING,  0,  0,  0, 8'h44, 0);
        queue_request(ACT_NUMBER,  5,  0,  0, 8'h00, 0);
        queue_request(ACT_NUMBER,  2,  0,  0, 8'h00, 7);
        queue_request(ACT_NUMBER, 10,  0,  0, 8'h00, 42);
        queue_request(ACT_NUMBER, 16,  0,  0, 8'h00, 999);
        queue_request(ACT_NUMBER, 20,  0,  0, 8'h00, 1000);
        queue_request(ACT_NUMBER, 26,  0,  0, 8'h00, 9999);
        queue_request(ACT_NUMBER, 28,  0,  0, 8'h00, 10000);
        queue_request(ACT_NUMBER, 63,  0,  0, 8'h00, 65535);
        queue_request(ACT_NUMBER,  0,  0,  0, 8'h00, 100);
        for (int i = 0; i < 4; i++) queue_request(ACT_TICK, 63, 63, 63, 8'hFF, 65535);
        queue_request(ACT_INIT, 0, 0, 0, 0, 0);
        for (int i = 0; i < 3; i++) queue_request(ACT_TICK, 0, 0, 0, 0, 0);

        while (stim_count < RANDOM_ITEMS) begin
            sel = $urandom_range(99);
            if (sel < 45) begin
                queue_request(ACT_TICK, $urandom_range(63), $urandom_range(63),
                              $urandom_range(63), $urandom_range(255), $urandom_range(65535));
                stim_count++;
            end else if (sel < 70) begin
                len   = ($urandom_range(9) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 8);
                start = $urandom_range(0, 32 - len);
                for (int off = 0; off < len; off++)
                    queue_request(ACT_STRING, start, len, off, $urandom_range(255),
                                  $urandom_range(65535));
                stim_count += len;
            end else if (sel < 88) begin
                start = ($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(31);
                queue_request(ACT_NUMBER, start, $urandom_range(63), $urandom_range(63),
                              $urandom_range(255), pick_number());
                stim_count++;
            end else if (sel < 93) begin
                queue_request(ACT_INIT, $urandom_range(63), $urandom_range(63),
                              $urandom_range(63), $urandom_range(255), $urandom_range(65535));
                stim_count++;
            end else begin
                queue_request(ACT_STRING, $urandom_range(63), $urandom_range(63),
                              $urandom_range(63), $urandom_range(255), $urandom_range(65535));
            end
        end

        @(posedge aclk);
        while (pending_requests.size() != 0 || s_valid) @(posedge aclk);
        while (expected_nibbles.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (failures == 0 && expected_nibbles.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/lcdr_pkg.sv
src/lcdr_in_stage.sv
src/lcdr_screen.sv
src/lcdr_nibble_out.sv
src/char_lcd_refresh_controller_core.sv
dv/testbench.sv
